/* hw/rtl/jhsp_pkg.sv */
// Package for the JPEG header segment parser: phase codes, marker codes,
// record kinds, status codes and the zigzag table. No dependencies.
`timescale 1ns / 1ps
package jhsp_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC0    = 4'd0,
    PH_MAGIC1    = 4'd1,
    PH_GROUP     = 4'd2,
    PH_SKIP      = 4'd3,
    PH_SOF       = 4'd4,
    PH_DQT_INFO  = 4'd5,
    PH_DQT_HI    = 4'd6,
    PH_DQT_LO    = 4'd7,
    PH_DHT_INFO  = 4'd8,
    PH_DHT_COUNT = 4'd9,
    PH_DHT_SYM   = 4'd10,
    PH_SOS       = 4'd11,
    PH_DRI       = 4'd12,
    PH_DRAIN     = 4'd13,
    PH_DONE      = 4'd14
  } phase_e;

  typedef enum logic [2:0] {
    RK_QUANT    = 3'd0,
    RK_DC_COUNT = 3'd1,
    RK_DC_SYM   = 3'd2,
    RK_AC_COUNT = 3'd3,
    RK_AC_SYM   = 3'd4,
    RK_FRAME    = 3'd5,
    RK_SCAN     = 3'd6,
    RK_DONE     = 3'd7
  } rec_kind_e;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC  = 2'd1;
  localparam logic [1:0] ST_NO_FRAME   = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  localparam logic [7:0] MK_SOF0 = 8'hC0;
  localparam logic [7:0] MK_SOF1 = 8'hC1;
  localparam logic [7:0] MK_DHT  = 8'hC4;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_DQT  = 8'hDB;
  localparam logic [7:0] MK_DRI  = 8'hDD;

  localparam int unsigned OK_SOF = 0;
  localparam int unsigned OK_DHT = 1;
  localparam int unsigned OK_SOS = 2;
  localparam int unsigned OK_DQT = 3;
  localparam int unsigned OK_DRI = 4;

  localparam logic [11:0] MAX_SYMBOLS = 12'd162;
  localparam logic [7:0]  SCAN_SE     = 8'd63;

  localparam logic [0:0] REG_HDR_ONLY = 1'b0;

  function automatic logic [7:0] zz_natural(input logic [5:0] k);
    logic [7:0] r;
    unique case (k)
      6'd0: r = 8'd0;   6'd1: r = 8'd1;   6'd2: r = 8'd8;   6'd3: r = 8'd16;
      6'd4: r = 8'd9;   6'd5: r = 8'd2;   6'd6: r = 8'd3;   6'd7: r = 8'd10;
      6'd8: r = 8'd17;  6'd9: r = 8'd24;  6'd10: r = 8'd32; 6'd11: r = 8'd25;
      6'd12: r = 8'd18; 6'd13: r = 8'd11; 6'd14: r = 8'd4;  6'd15: r = 8'd5;
      6'd16: r = 8'd12; 6'd17: r = 8'd19; 6'd18: r = 8'd26; 6'd19: r = 8'd33;
      6'd20: r = 8'd40; 6'd21: r = 8'd48; 6'd22: r = 8'd41; 6'd23: r = 8'd34;
      6'd24: r = 8'd27; 6'd25: r = 8'd20; 6'd26: r = 8'd13; 6'd27: r = 8'd6;
      6'd28: r = 8'd7;  6'd29: r = 8'd14; 6'd30: r = 8'd21; 6'd31: r = 8'd28;
      6'd32: r = 8'd35; 6'd33: r = 8'd42; 6'd34: r = 8'd49; 6'd35: r = 8'd56;
      6'd36: r = 8'd57; 6'd37: r = 8'd50; 6'd38: r = 8'd43; 6'd39: r = 8'd36;
      6'd40: r = 8'd29; 6'd41: r = 8'd22; 6'd42: r = 8'd15; 6'd43: r = 8'd23;
      6'd44: r = 8'd30; 6'd45: r = 8'd37; 6'd46: r = 8'd44; 6'd47: r = 8'd51;
      6'd48: r = 8'd58; 6'd49: r = 8'd59; 6'd50: r = 8'd52; 6'd51: r = 8'd45;
      6'd52: r = 8'd38; 6'd53: r = 8'd31; 6'd54: r = 8'd39; 6'd55: r = 8'd46;
      6'd56: r = 8'd53; 6'd57: r = 8'd60; 6'd58: r = 8'd61; 6'd59: r = 8'd54;
      6'd60: r = 8'd47; 6'd61: r = 8'd55; 6'd62: r = 8'd62; default: r = 8'd63;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/jpeg_header_segment_parser_unit.sv */
// JPEG header segment parser top level: byte-wise marker segment parsing,
// record generation and the APB register. Depends on jhsp_pkg.
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid_i/stall_o | data_byte_i, stream_end_i
//   out     | source    | out_valid_o/stall_i| record_kind_o .. frame_type_o
//   cfg     | sink      | APB psel/penable   | header_info_only (addr 0)
//
// One byte per cycle while in_stall_o is low; the parse state is updated in the accept
// cycle and the record lands in the output register.
// A full output register stalls the input only while the sink stalls.
// After reset the block expects FF D8; after the done record it drops bytes.
`timescale 1ns / 1ps
module jpeg_header_segment_parser_unit #(
  parameter int unsigned COMPONENT_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  record_kind_o,
  output logic [2:0]  table_id_o,
  output logic [7:0]  entry_index_o,
  output logic [15:0] entry_value_o,
  output logic [1:0]  status_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [7:0]  sample_precision_o,
  output logic [7:0]  component_count_o,
  output logic [15:0] restart_interval_o,
  output logic [7:0]  frame_type_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jhsp_pkg::*;

  localparam int unsigned SW = COMPONENT_SLOTS;

  logic hdr_only_q;
  phase_e ph_q, ph_d;
  logic [1:0] gpos_q, gpos_d;
  logic [7:0] mk_q, mk_d;
  logic [15:0] rem_q, rem_d, off_q, off_d;
  logic [4:0] okf_q, okf_d;
  logic fail_q, fail_d;
  logic [7:0] fcc_q, fcc_d;
  logic zb_q, zb_d;
  logic [SW-1:0] fseen_q, fseen_d, sseen_q, sseen_d;
  logic [7:0] sct_q, sct_d, tib_q, tib_d, sub_q, sub_d, hb_q, hb_d;
  logic [11:0] symt_q, symt_d;
  logic [15:0] w_q, w_d, h_q, h_d, rst_q, rst_d;
  logic [7:0] prec_q, prec_d, ft_q, ft_d;

  logic acc, fin, badm, rec_on, seg_end;
  logic [2:0] rk, rt;
  logic [7:0] ri;
  logic [15:0] rv;
  logic [1:0] st;

  logic ov_q;
  logic [2:0] ork_q, ot_q;
  logic [7:0] oi_q, op_q, oc_q, of_q;
  logic [15:0] ov16_q, ow_q, oh_q, orr_q;
  logic [1:0] os_q;

  assign pready = 1'b1;
  assign prdata = (paddr == {REG_HDR_ONLY, 1'b0}) ? {31'd0, hdr_only_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_only_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == {REG_HDR_ONLY, 1'b0}) begin
      hdr_only_q <= pwdata[0];
    end
  end

  assign in_stall_o = ov_q && out_stall_i;
  assign acc = in_valid_i && !in_stall_o;

  // slot id, offset and length helpers
  logic [8:0] fid, sid;
  logic [17:0] k3;
  logic [16:0] n2;
  logic [16:0] kk;
  logic fin_seg;
  logic [15:0] len;
  logic [1:0] kmod;

  always_comb begin
    ph_d = ph_q; gpos_d = gpos_q; mk_d = mk_q; rem_d = rem_q; off_d = off_q;
    okf_d = okf_q; fail_d = fail_q; fcc_d = fcc_q; zb_d = zb_q;
    fseen_d = fseen_q; sseen_d = sseen_q; sct_d = sct_q; tib_d = tib_q;
    sub_d = sub_q; hb_d = hb_q; symt_d = symt_q; w_d = w_q; h_d = h_q;
    rst_d = rst_q; prec_d = prec_q; ft_d = ft_q;
    fin = 1'b0; badm = 1'b0; rec_on = 1'b0; seg_end = 1'b0;
    rk = RK_QUANT; rt = 3'd0; ri = 8'd0; rv = 16'd0;
    fid = 9'd0; sid = 9'd0; k3 = 18'd0; n2 = 17'd0; kk = 17'd0;
    fin_seg = 1'b0; len = 16'd0; kmod = 2'd0;
    unique case (ph_q)
      PH_DONE: ;
      PH_MAGIC0: begin
        if (data_byte_i == 8'hFF) ph_d = PH_MAGIC1;
        else begin fin = 1'b1; badm = 1'b1; end
      end
      PH_MAGIC1: begin
        if (data_byte_i == 8'hD8) ph_d = PH_GROUP;
        else begin fin = 1'b1; badm = 1'b1; end
      end
      PH_GROUP: begin
        gpos_d = gpos_q + 2'd1;
        unique case (gpos_q)
          2'd0: hb_d = data_byte_i;
          2'd1: mk_d = data_byte_i;
          2'd2: rem_d = {data_byte_i, 8'd0};
          default: begin
            len = rem_q | {8'd0, data_byte_i};
            rem_d = 16'd0;
            if (hb_q == 8'hFF) begin
              rem_d = (len < 16'd2) ? 16'd0 : len - 16'd2;
              off_d = 16'd0;
              fail_d = 1'b0;
              if (mk_q == MK_SOF0 || mk_q == MK_SOF1) begin
                ph_d = PH_SOF;
                sub_d = 8'd0;
                if (fcc_q != 8'd0) begin fail_d = 1'b1; ph_d = PH_DRAIN; end
                else ft_d = mk_q;
              end else if (mk_q == MK_DQT) ph_d = PH_DQT_INFO;
              else if (mk_q == MK_DHT) ph_d = hdr_only_q ? PH_SKIP : PH_DHT_INFO;
              else if (mk_q == MK_SOS) begin
                ph_d = PH_SOS; sseen_d = '0; sct_d = 8'd0;
                if (fcc_q == 8'd0) begin fail_d = 1'b1; ph_d = PH_DRAIN; end
              end else if (mk_q == MK_DRI) ph_d = PH_DRI;
              else ph_d = PH_SKIP;
              if (rem_d == 16'd0) seg_end = 1'b1;
            end
          end
        endcase
      end
      default: begin
        unique case (ph_q)
          PH_SOF: begin
            unique case (off_q)
              16'd0: prec_d = data_byte_i;
              16'd1: hb_d = data_byte_i;
              16'd2: h_d = {hb_q, data_byte_i};
              16'd3: hb_d = data_byte_i;
              16'd4: w_d = {hb_q, data_byte_i};
              16'd5: fcc_d = data_byte_i;
              default: begin
                kk = {1'b0, off_q} - 17'd6;
                // group counter: position within a 3-byte component
                kmod = sub_q[1:0];
                if ({1'b0, kk} < 18'd3 * {10'd0, fcc_q}) begin
                  unique case (kmod)
                    2'd0: begin
                      fid = {1'b0, data_byte_i} + {8'd0, (data_byte_i == 8'd0) | zb_q};
                      if (data_byte_i == 8'd0) zb_d = 1'b1;
                      if (fid == 9'd0 || fid > 9'(SW) || fseen_q[fid[2:0] - 3'd1]) begin
                        fail_d = 1'b1; ph_d = PH_DRAIN;
                      end else begin
                        fseen_d[fid[2:0] - 3'd1] = 1'b1;
                        tib_d = {5'd0, fid[2:0] - 3'd1};
                      end
                    end
                    2'd1: hb_d = data_byte_i;
                    default: begin
                      rec_on = 1'b1; rk = RK_FRAME; rt = tib_q[2:0];
                      rv = {hb_q, data_byte_i};
                      if (data_byte_i > 8'd3) begin fail_d = 1'b1; ph_d = PH_DRAIN; end
                    end
                  endcase
                end
                sub_d = (kmod == 2'd2) ? 8'd0 : sub_q + 8'd1;
              end
            endcase
          end
          PH_SOS: begin
            n2 = {8'd0, sct_q, 1'b0};
            if (off_q == 16'd0) sct_d = data_byte_i;
            else if ({1'b0, off_q} <= n2) begin
              if (off_q[0]) begin
                sid = {1'b0, data_byte_i} + {8'd0, zb_q};
                if (sid == 9'd0 || sid > {1'b0, fcc_q} || sid > 9'(SW) ||
                    sseen_q[sid[2:0] - 3'd1]) begin
                  fail_d = 1'b1; ph_d = PH_DRAIN;
                end else begin
                  sseen_d[sid[2:0] - 3'd1] = 1'b1;
                  tib_d = {5'd0, sid[2:0] - 3'd1};
                end
              end else begin
                rec_on = 1'b1; rk = RK_SCAN; rt = tib_q[2:0];
                rv = {8'd0, data_byte_i};
                if (data_byte_i[7:4] > 4'd3 || data_byte_i[3:0] > 4'd3) begin
                  fail_d = 1'b1; ph_d = PH_DRAIN;
                end
              end
            end else begin
              kk = {1'b0, off_q} - n2;
              if (!((kk == 17'd1 && data_byte_i == 8'd0) ||
                    (kk == 17'd2 && data_byte_i == SCAN_SE) ||
                    (kk == 17'd3 && data_byte_i == 8'd0))) begin
                fail_d = 1'b1; ph_d = PH_DRAIN;
              end
            end
          end
          PH_DRI: begin
            if (off_q == 16'd0) hb_d = data_byte_i;
            else if (off_q == 16'd1) rst_d = {hb_q, data_byte_i};
          end
          PH_DQT_INFO: begin
            tib_d = data_byte_i;
            if (data_byte_i[3:0] > 4'd3) begin fail_d = 1'b1; ph_d = PH_DRAIN; end
            else begin
              sub_d = 8'd0;
              ph_d = (data_byte_i[7:4] != 4'd0) ? PH_DQT_HI : PH_DQT_LO;
            end
          end
          PH_DQT_HI: begin hb_d = data_byte_i; ph_d = PH_DQT_LO; end
          PH_DQT_LO: begin
            rec_on = 1'b1; rk = RK_QUANT; rt = tib_q[2:0];
            ri = zz_natural(sub_q[5:0]);
            rv = (tib_q[7:4] != 4'd0) ? {hb_q, data_byte_i} : {8'd0, data_byte_i};
            sub_d = sub_q + 8'd1;
            if (sub_d >= 8'd64) ph_d = PH_DQT_INFO;
            else ph_d = (tib_q[7:4] != 4'd0) ? PH_DQT_HI : PH_DQT_LO;
          end
          PH_DHT_INFO: begin
            tib_d = data_byte_i;
            if (data_byte_i[3:0] > 4'd3 || data_byte_i[7:4] > 4'd1) begin
              fail_d = 1'b1; ph_d = PH_DRAIN;
            end else begin
              sub_d = 8'd0; symt_d = 12'd0; ph_d = PH_DHT_COUNT;
            end
          end
          PH_DHT_COUNT: begin
            symt_d = symt_q + {4'd0, data_byte_i};
            rec_on = 1'b1; rk = (tib_q[7:4] != 4'd0) ? RK_AC_COUNT : RK_DC_COUNT;
            rt = tib_q[2:0]; ri = sub_q + 8'd1; rv = {4'd0, symt_d};
            sub_d = sub_q + 8'd1;
            if (sub_d >= 8'd16) begin
              sub_d = 8'd0;
              if (symt_d > MAX_SYMBOLS) begin fail_d = 1'b1; ph_d = PH_DRAIN; end
              else ph_d = (symt_d == 12'd0) ? PH_DHT_INFO : PH_DHT_SYM;
            end
          end
          PH_DHT_SYM: begin
            rec_on = 1'b1; rk = (tib_q[7:4] != 4'd0) ? RK_AC_SYM : RK_DC_SYM;
            rt = tib_q[2:0]; ri = sub_q; rv = {8'd0, data_byte_i};
            sub_d = sub_q + 8'd1;
            if ({4'd0, sub_d} >= symt_q) ph_d = PH_DHT_INFO;
          end
          default: ;
        endcase
        off_d = off_q + 16'd1;
        rem_d = rem_q - 16'd1;
        if (rem_d == 16'd0) seg_end = 1'b1;
      end
    endcase

    // segment close, evaluated on the updated state
    if (seg_end) begin
      if (ph_d != PH_SKIP) begin
        if (mk_q == MK_SOF0 || mk_q == MK_SOF1) begin
          k3 = 18'd6 + 18'd3 * {10'd0, fcc_d};
          okf_d[OK_SOF] = !fail_d && off_d >= 16'd6 && {2'd0, off_d} >= k3 &&
                          prec_d >= 8'd1 && prec_d <= 8'd16 && fcc_d >= 8'd1 &&
                          fcc_d <= 8'(SW) && h_d != 16'd0 && w_d != 16'd0;
        end else if (mk_q == MK_DQT) okf_d[OK_DQT] = !fail_d && ph_d == PH_DQT_INFO;
        else if (mk_q == MK_DHT) okf_d[OK_DHT] = !fail_d && ph_d == PH_DHT_INFO;
        else if (mk_q == MK_SOS) begin
          okf_d[OK_SOS] = !fail_d && off_d >= 16'd1 &&
                          {1'b0, off_d} == 17'd4 + {8'd0, sct_d, 1'b0};
          fin_seg = 1'b1;
        end else if (mk_q == MK_DRI) okf_d[OK_DRI] = !fail_d && off_d >= 16'd2;
      end
      ph_d = PH_GROUP;
    end
    if (fin_seg) fin = 1'b1;
    if (stream_end_i && ph_q != PH_DONE) fin = 1'b1;

    if (ph_q == PH_MAGIC0 || ph_q == PH_MAGIC1) begin
      if (ph_d == PH_MAGIC0 || ph_d == PH_MAGIC1) badm = badm | fin;
    end
    if (badm) st = ST_BAD_MAGIC;
    else if (!okf_d[OK_SOF]) st = ST_NO_FRAME;
    else if (hdr_only_q) st = ST_OK;
    else if (!(okf_d[OK_DHT] && okf_d[OK_SOS] && okf_d[OK_DQT] && okf_d[OK_DRI]))
      st = ST_INCOMPLETE;
    else st = ST_OK;
    if (fin) ph_d = PH_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_MAGIC0; gpos_q <= 2'd0; mk_q <= 8'd0; rem_q <= 16'd0;
      off_q <= 16'd0; okf_q <= 5'd0; fail_q <= 1'b0; fcc_q <= 8'd0; zb_q <= 1'b0;
      fseen_q <= '0; sseen_q <= '0; sct_q <= 8'd0; tib_q <= 8'd0; sub_q <= 8'd0;
      hb_q <= 8'd0; symt_q <= 12'd0; w_q <= 16'd0; h_q <= 16'd0;
      rst_q <= 16'd0; prec_q <= 8'd0; ft_q <= 8'd0;
    end else if (acc) begin
      ph_q <= ph_d; gpos_q <= gpos_d; mk_q <= mk_d; rem_q <= rem_d;
      off_q <= off_d; okf_q <= okf_d; fail_q <= fail_d; fcc_q <= fcc_d; zb_q <= zb_d;
      fseen_q <= fseen_d; sseen_q <= sseen_d; sct_q <= sct_d; tib_q <= tib_d;
      sub_q <= (ph_q == PH_SOF && ph_d != PH_SOF) ? 8'd0 : sub_d;
      hb_q <= hb_d; symt_q <= symt_d; w_q <= w_d; h_q <= h_d;
      rst_q <= rst_d; prec_q <= prec_d; ft_q <= ft_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (!(ov_q && out_stall_i)) begin
      ov_q <= acc && ph_q != PH_DONE && (fin || rec_on);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!(ov_q && out_stall_i)) begin
      if (fin) begin
        ork_q <= RK_DONE; ot_q <= 3'd0; oi_q <= 8'd0; ov16_q <= 16'd0;
        os_q <= st; ow_q <= w_d; oh_q <= h_d; op_q <= prec_d; oc_q <= fcc_d;
        orr_q <= rst_d; of_q <= ft_d;
      end else begin
        ork_q <= rk; ot_q <= rt; oi_q <= ri; ov16_q <= rv;
        os_q <= 2'd0; ow_q <= 16'd0; oh_q <= 16'd0; op_q <= 8'd0; oc_q <= 8'd0;
        orr_q <= 16'd0; of_q <= 8'd0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign record_kind_o = ork_q;
  assign table_id_o = ot_q;
  assign entry_index_o = oi_q;
  assign entry_value_o = ov16_q;
  assign status_o = os_q;
  assign image_width_o = ow_q;
  assign image_height_o = oh_q;
  assign sample_precision_o = op_q;
  assign component_count_o = oc_q;
  assign restart_interval_o = orr_q;
  assign frame_type_o = of_q;

  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_DONE) |=> (ph_q == PH_DONE)) else $error("left done phase");
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_DONE && !ov_q) |=> !out_valid_o) else $error("record after done");
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o) else $error("input taken while full");
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_kind_o != RK_DONE) |-> (status_o == ST_OK))
    else $error("status on non-done record");
endmodule
